[rtl/sdmd_pkg.sv]
// ----------------------------------------------------------------------------
// Sigma-Delta motion detect package
// Shared widths, register map, reset values and the types that pass between
// the front queue, the update pipeline and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sdmd_pkg;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int ADDR_W = 16;
    localparam int AMP_W  = 4;
    localparam int VAR_W  = 8;

    // Background store depth (one entry per raster position)
    localparam int FRAME_PIXELS = 65536;

    // Front queue depth and its pointer and count widths
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_AMP_FACTOR = 2'd0,
        REG_VAR_MIN    = 2'd1,
        REG_VAR_MAX    = 2'd2
    } reg_idx_t;

    localparam logic [AMP_W-1:0] AMP_RESET     = 4'd4;
    localparam logic [VAR_W-1:0] VAR_MIN_RESET = 8'd1;
    localparam logic [VAR_W-1:0] VAR_MAX_RESET = 8'd254;

    // Kind of work an item asks of the back end
    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_INIT   = 1'b1
    } op_t;

    // One classified item as it sits in the queue
    typedef struct packed {
        op_t               op;
        logic [PIX_W-1:0]  pixel;
        logic [ADDR_W-1:0] addr;
    } item_t;

    // Live configuration
    typedef struct packed {
        logic [AMP_W-1:0] amp_factor;
        logic [VAR_W-1:0] var_min;
        logic [VAR_W-1:0] var_max;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/sdmd_front.sv]
// ----------------------------------------------------------------------------
// Sigma-Delta motion detect front end
// Accepts input transfers, classifies each pixel as a first-frame load or a
// background update, and holds the items in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmd_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [sdmd_pkg::PIX_W-1:0]  pixel,
    input  wire logic [sdmd_pkg::ADDR_W-1:0] pixel_addr,
    input  wire logic                       init_frame,
    output logic                            q_valid,
    input  wire logic                       q_ready,
    output sdmd_pkg::item_t                 q_item
);

    sdmd_pkg::item_t                  slot_reg [sdmd_pkg::QUEUE_DEPTH];
    logic [sdmd_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [sdmd_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [sdmd_pkg::QCNT_W-1:0]      count_reg;
    logic                             push;
    logic                             pop;
    sdmd_pkg::item_t                  item_next;

    // Handshake on both sides of the queue.
    assign in_ready = (count_reg != sdmd_pkg::QCNT_W'(sdmd_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_item   = slot_reg[rd_ptr_reg];

    // Classify the incoming pixel.
    always_comb
    begin
        item_next.op    = init_frame ? sdmd_pkg::OP_INIT : sdmd_pkg::OP_UPDATE;
        item_next.pixel = pixel;
        item_next.addr  = pixel_addr;
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_next;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/sdmd_back.sv]
// ----------------------------------------------------------------------------
// Sigma-Delta motion detect back end
// Two-stage read-modify-write pipeline over the background store, with
// forwarding of the last write and a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmd_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sdmd_pkg::cfg_t              cfg,
    input  wire logic                        q_valid,
    output logic                             q_ready,
    input  wire sdmd_pkg::item_t             q_item,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             motion,
    output logic [sdmd_pkg::ADDR_W-1:0]      out_addr
);

    localparam int ENTRY_W = sdmd_pkg::PIX_W + sdmd_pkg::VAR_W;
    localparam int PROD_W  = sdmd_pkg::PIX_W + sdmd_pkg::AMP_W;

    // Background store: mean in the upper byte, variance in the lower byte.
    logic [ENTRY_W-1:0]              mem [sdmd_pkg::FRAME_PIXELS];
    logic [ENTRY_W-1:0]              rdata_reg;

    logic                            e_valid_reg;
    sdmd_pkg::item_t                 e_item_reg;
    logic                            prev_valid_reg;
    logic [sdmd_pkg::ADDR_W-1:0]     prev_addr_reg;
    logic [ENTRY_W-1:0]              prev_data_reg;
    logic                            out_valid_reg;
    logic                            motion_reg;
    logic [sdmd_pkg::ADDR_W-1:0]     out_addr_reg;

    logic                            adv;
    logic                            wr_en;
    logic                            fwd;
    logic [sdmd_pkg::PIX_W-1:0]      cur_mean;
    logic [sdmd_pkg::VAR_W-1:0]      cur_var;
    logic [sdmd_pkg::PIX_W-1:0]      step_mean;
    logic [sdmd_pkg::PIX_W-1:0]      diff;
    logic [PROD_W-1:0]               prod;
    logic [sdmd_pkg::VAR_W-1:0]      target;
    logic [sdmd_pkg::VAR_W-1:0]      step_var;
    logic [sdmd_pkg::VAR_W-1:0]      clamp_hi;
    logic [sdmd_pkg::PIX_W-1:0]      mean_next;
    logic [sdmd_pkg::VAR_W-1:0]      var_next;
    logic                            motion_next;

    // The whole pipeline moves when the output register can take a result.
    assign adv     = !out_valid_reg || out_ready;
    assign q_ready = adv;
    assign wr_en   = adv && e_valid_reg;

    // The item read in the same cycle as the previous write saw stale data.
    assign fwd      = prev_valid_reg && (prev_addr_reg == e_item_reg.addr);
    assign cur_mean = fwd ? prev_data_reg[ENTRY_W-1:sdmd_pkg::VAR_W]
                          : rdata_reg[ENTRY_W-1:sdmd_pkg::VAR_W];
    assign cur_var  = fwd ? prev_data_reg[sdmd_pkg::VAR_W-1:0]
                          : rdata_reg[sdmd_pkg::VAR_W-1:0];

    // Mean steps toward the pixel, variance toward the scaled difference.
    always_comb
    begin
        if (cur_mean < e_item_reg.pixel)
        begin
            step_mean = cur_mean + 1'b1;
        end
        else if (cur_mean > e_item_reg.pixel)
        begin
            step_mean = cur_mean - 1'b1;
        end
        else
        begin
            step_mean = cur_mean;
        end

        diff = (step_mean > e_item_reg.pixel) ? (step_mean - e_item_reg.pixel)
                                              : (e_item_reg.pixel - step_mean);
        prod = PROD_W'(diff) * PROD_W'(cfg.amp_factor);
        target = (prod[PROD_W-1:sdmd_pkg::VAR_W] != '0) ? '1
                                                        : prod[sdmd_pkg::VAR_W-1:0];

        if (cur_var < target)
        begin
            step_var = cur_var + 1'b1;
        end
        else if (cur_var > target)
        begin
            step_var = cur_var - 1'b1;
        end
        else
        begin
            step_var = cur_var;
        end

        // The lower clamp wins when the limits cross.
        clamp_hi = (step_var > cfg.var_max) ? cfg.var_max : step_var;
    end

    // Select between the first-frame load and the background update.
    always_comb
    begin
        unique case (e_item_reg.op)
            sdmd_pkg::OP_INIT:
            begin
                mean_next   = e_item_reg.pixel;
                var_next    = cfg.var_min;
                motion_next = 1'b0;
            end
            sdmd_pkg::OP_UPDATE:
            begin
                mean_next   = step_mean;
                var_next    = (clamp_hi < cfg.var_min) ? cfg.var_min : clamp_hi;
                motion_next = (diff >= var_next);
            end
            default:
            begin
                mean_next   = step_mean;
                var_next    = cfg.var_min;
                motion_next = 1'b0;
            end
        endcase
    end

    // Store read and write ports.
    always_ff @(posedge clk)
    begin
        if (adv && q_valid)
        begin
            rdata_reg <= mem[q_item.addr];
        end
        if (wr_en)
        begin
            mem[e_item_reg.addr] <= {mean_next, var_next};
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_item_reg    <= q_item;
            prev_addr_reg <= e_item_reg.addr;
            prev_data_reg <= {mean_next, var_next};
            motion_reg    <= motion_next;
            out_addr_reg  <= e_item_reg.addr;
        end
    end

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg    <= q_valid;
            prev_valid_reg <= e_valid_reg;
            out_valid_reg  <= e_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign motion    = motion_reg;
    assign out_addr  = out_addr_reg;

    // A stalled pipeline keeps its working item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && e_valid_reg) |=> (e_valid_reg && $stable(e_item_reg)))
        else $error("update stage lost its item during a stall");

    // The store is written only while the output register takes the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> out_valid_reg)
        else $error("store written without a matching result");

    // The forwarding register tracks the last written address.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (prev_valid_reg && (prev_addr_reg == $past(e_item_reg.addr))))
        else $error("forwarding register out of step with the store write");

    // A first-frame load never reports motion.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (e_item_reg.op == sdmd_pkg::OP_INIT)) |=> !motion_reg)
        else $error("motion reported on a first-frame pixel");

endmodule

`default_nettype wire

[rtl/sigma_delta_motion_detect_core.sv]
// ----------------------------------------------------------------------------
// Sigma-Delta motion detect core
// Per-pixel Sigma-Delta background subtraction with an APB-style register
// port for the amplification factor and the variance limits.
// ----------------------------------------------------------------------------
// The core takes one pixel transfer per clock while out_ready stays high and
// returns one motion result per pixel, in order, with out_addr echoing the
// pixel address. When nothing stalls, a pixel waits in the input queue, is
// read from the background store into the update stage, and its update lands
// in the output register. Sustained rate is one pixel per cycle while
// out_ready stays high, set by the single read and single write the store
// makes per pixel; back-to-back pixels at the same address are handled by
// forwarding the last write. The four-entry input queue lets the pixel source
// run on while the result sink stalls. The store has no reset: every address
// must see a first-frame pixel (init_frame high) before it sees an update.
`default_nettype none

module sigma_delta_motion_detect_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sdmd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [sdmd_pkg::PDATA_W-1:0]  pwdata,
    output logic [sdmd_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sdmd_pkg::PIX_W-1:0]    pixel,
    input  wire logic [sdmd_pkg::ADDR_W-1:0]   pixel_addr,
    input  wire logic                          init_frame,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               motion,
    output logic [sdmd_pkg::ADDR_W-1:0]        out_addr
);

    logic [sdmd_pkg::AMP_W-1:0]     amp_factor_reg;
    logic [sdmd_pkg::VAR_W-1:0]     var_min_reg;
    logic [sdmd_pkg::VAR_W-1:0]     var_max_reg;
    logic                           cfg_wr;
    sdmd_pkg::reg_idx_t             reg_idx;
    sdmd_pkg::cfg_t                 cfg;
    logic                           q_valid;
    logic                           q_ready;
    sdmd_pkg::item_t                q_item;

    // Register decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = sdmd_pkg::reg_idx_t'(paddr[sdmd_pkg::REG_IDX_W+1:2]);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_factor_reg <= sdmd_pkg::AMP_RESET;
            var_min_reg    <= sdmd_pkg::VAR_MIN_RESET;
            var_max_reg    <= sdmd_pkg::VAR_MAX_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                sdmd_pkg::REG_AMP_FACTOR: amp_factor_reg <= pwdata[sdmd_pkg::AMP_W-1:0];
                sdmd_pkg::REG_VAR_MIN:    var_min_reg    <= pwdata[sdmd_pkg::VAR_W-1:0];
                sdmd_pkg::REG_VAR_MAX:    var_max_reg    <= pwdata[sdmd_pkg::VAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (reg_idx)
            sdmd_pkg::REG_AMP_FACTOR: prdata = sdmd_pkg::PDATA_W'(amp_factor_reg);
            sdmd_pkg::REG_VAR_MIN:    prdata = sdmd_pkg::PDATA_W'(var_min_reg);
            sdmd_pkg::REG_VAR_MAX:    prdata = sdmd_pkg::PDATA_W'(var_max_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.amp_factor = amp_factor_reg;
        cfg.var_min    = var_min_reg;
        cfg.var_max    = var_max_reg;
    end

    // Input acceptance and queue.
    sdmd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .pixel_addr (pixel_addr),
        .init_frame (init_frame),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    // Background update pipeline.
    sdmd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .motion    (motion),
        .out_addr  (out_addr)
    );

endmodule

`default_nettype wire

[tb/tb_sigma_delta_motion_detect_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sigma-Delta motion detect core testbench
// Streams pixels into the core and checks each motion result, in order,
// against an internal copy of the per-pixel background mean and variance.
// Register settings change only while the core is idle. A directed part
// covers field extremes and the corner settings; random frames follow.
// ----------------------------------------------------------------------------

module tb_sigma_delta_motion_detect_core;

    localparam int CLK_HIGH_NS   = 10;
    localparam int CLK_LOW_NS    = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_PIXELS  = 142;
    localparam int HOT_ADDRS     = 24;

    // One expected motion result
    typedef struct packed {
        logic                        motion;
        logic [sdmd_pkg::ADDR_W-1:0] addr;
    } motion_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [sdmd_pkg::PADDR_W-1:0]  paddr = '0;
    logic [sdmd_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [sdmd_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [sdmd_pkg::PIX_W-1:0]    pixel = '0;
    logic [sdmd_pkg::ADDR_W-1:0]   pixel_addr = '0;
    logic                          init_frame = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          motion;
    logic [sdmd_pkg::ADDR_W-1:0]   out_addr;

    // Background model kept by the testbench
    logic [sdmd_pkg::PIX_W-1:0]    bg_mean [sdmd_pkg::FRAME_PIXELS];
    logic [sdmd_pkg::VAR_W-1:0]    bg_var [sdmd_pkg::FRAME_PIXELS];
    bit                            seeded [sdmd_pkg::FRAME_PIXELS];
    logic [sdmd_pkg::ADDR_W-1:0]   seeded_addrs [$];
    logic [sdmd_pkg::AMP_W-1:0]    amp_cfg = sdmd_pkg::AMP_RESET;
    logic [sdmd_pkg::VAR_W-1:0]    var_min_cfg = sdmd_pkg::VAR_MIN_RESET;
    logic [sdmd_pkg::VAR_W-1:0]    var_max_cfg = sdmd_pkg::VAR_MAX_RESET;

    motion_result_t                motion_q [$];
    logic [sdmd_pkg::ADDR_W-1:0]   last_addr = '0;
    bit                            idle_on = 1'b1;
    int                            error_count = 0;
    int                            cycle_count = 0;
    int                            stall_left = 0;

    sigma_delta_motion_detect_core i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .pixel_addr (pixel_addr),
        .init_frame (init_frame),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .motion     (motion),
        .out_addr   (out_addr)
    );

    // Clock generation
    always
    begin
        #CLK_HIGH_NS clk = 1'b1;
        #CLK_LOW_NS  clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_sigma_delta_motion_detect_core: errors");
            $finish;
        end
    end

    // Random idle length: mostly short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [7:0] step_toward(input logic [7:0] cur, input logic [7:0] goal);
        if (cur < goal)
            return cur + 8'd1;
        if (cur > goal)
            return cur - 8'd1;
        return cur;
    endfunction

    // Update the background of one address and queue the expected result.
    task automatic predict_motion(input logic [sdmd_pkg::PIX_W-1:0] pix,
                                  input logic [sdmd_pkg::ADDR_W-1:0] addr,
                                  input logic first);
        motion_result_t             res;
        logic [sdmd_pkg::PIX_W-1:0] m;
        logic [sdmd_pkg::PIX_W-1:0] diff;
        logic [11:0]                prod;
        logic [sdmd_pkg::VAR_W-1:0] goal;
        logic [sdmd_pkg::VAR_W-1:0] v;
        res.addr = addr;
        res.motion = 1'b0;
        if (first)
        begin
            bg_mean[addr] = pix;
            bg_var[addr] = var_min_cfg;
            if (!seeded[addr])
            begin
                seeded[addr] = 1'b1;
                seeded_addrs.push_back(addr);
            end
        end
        else
        begin
            m = step_toward(bg_mean[addr], pix);
            diff = (m > pix) ? m - pix : pix - m;
            prod = diff * amp_cfg;
            goal = (prod > 12'd255) ? 8'd255 : prod[7:0];
            v = step_toward(bg_var[addr], goal);
            // The lower clamp wins when the limits are inverted.
            if (v > var_max_cfg)
                v = var_max_cfg;
            if (v < var_min_cfg)
                v = var_min_cfg;
            bg_mean[addr] = m;
            bg_var[addr] = v;
            res.motion = (diff >= v);
        end
        motion_q.push_back(res);
    endtask

    // Send one pixel; valid stays high afterwards unless a gap follows.
    task automatic send_pixel(input logic [sdmd_pkg::PIX_W-1:0] pix_value,
                              input logic [sdmd_pkg::ADDR_W-1:0] addr_value,
                              input logic first);
        int gap;
        in_valid <= 1'b1;
        pixel <= pix_value;
        pixel_addr <= addr_value;
        init_frame <= first;
        do
            @(posedge clk);
        while (!in_ready);
        predict_motion(pix_value, addr_value, first);
        last_addr = addr_value;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected result has come out or the drain limit is reached.
    task automatic wait_idle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (motion_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_register(input sdmd_pkg::reg_idx_t idx,
                                  input logic [sdmd_pkg::PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        unique case (idx)
            sdmd_pkg::REG_AMP_FACTOR: amp_cfg = value[sdmd_pkg::AMP_W-1:0];
            sdmd_pkg::REG_VAR_MIN:    var_min_cfg = value[sdmd_pkg::VAR_W-1:0];
            sdmd_pkg::REG_VAR_MAX:    var_max_cfg = value[sdmd_pkg::VAR_W-1:0];
            default:                  ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_limits(input int amp, input int vmin, input int vmax);
        wait_idle();
        write_register(sdmd_pkg::REG_AMP_FACTOR, amp);
        write_register(sdmd_pkg::REG_VAR_MIN, vmin);
        write_register(sdmd_pkg::REG_VAR_MAX, vmax);
    endtask

    // Pixel for an update: near the background, random, or at either end of the range.
    function automatic logic [sdmd_pkg::PIX_W-1:0] pick_pixel(
        input logic [sdmd_pkg::PIX_W-1:0] mean);
        int r;
        int p;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            p = int'(mean) + $urandom_range(0, 6) - 3;
            if (p < 0)
                p = 0;
            if (p > 255)
                p = 255;
            return sdmd_pkg::PIX_W'(p);
        end
        else if (r < 70)
            return sdmd_pkg::PIX_W'($urandom_range(0, 255));
        else if (r < 85)
            return 8'd0;
        return 8'd255;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Result sink back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 99) < 20)
        begin
            out_ready <= 1'b0;
            stall_left <= idle_length() - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Result checker: each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        motion_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (motion_q.size() == 0)
            begin
                note_failure($sformatf("result with nothing expected: motion %b addr %h",
                                       motion, out_addr));
            end
            else
            begin
                exp_res = motion_q.pop_front();
                if (motion !== exp_res.motion || out_addr !== exp_res.addr)
                    note_failure($sformatf("mismatch: expected motion %b addr %h, got %b %h",
                                           exp_res.motion, exp_res.addr, motion, out_addr));
            end
        end
    end

    // Reset settings: extremes of pixel and address, back-to-back updates.
    task automatic test_reset_settings();
        idle_on = 1'b0;
        send_pixel(8'd0, 16'h0000, 1'b1);
        send_pixel(8'd255, 16'hFFFF, 1'b1);
        send_pixel(8'd128, 16'h1234, 1'b1);
        send_pixel(8'd0, 16'h0000, 1'b0);
        send_pixel(8'd0, 16'hFFFF, 1'b0);
        send_pixel(8'd0, 16'hFFFF, 1'b0);
        send_pixel(8'd255, 16'h0000, 1'b0);
        send_pixel(8'd128, 16'h1234, 1'b0);
        send_pixel(8'd128, 16'h1234, 1'b0);
        idle_on = 1'b1;
    endtask

    // Zero gain: the variance falls toward zero and rests on the minimum.
    task automatic test_zero_gain();
        set_limits(0, 1, 254);
        idle_on = 1'b0;
        send_pixel(8'd0, 16'hFFFF, 1'b0);
        send_pixel(8'd0, 16'hFFFF, 1'b0);
        send_pixel(8'd200, 16'h0000, 1'b1);
        send_pixel(8'd90, 16'h0000, 1'b0);
        idle_on = 1'b1;
    endtask

    // Minimum above maximum: the minimum decides the variance.
    task automatic test_inverted_limits();
        set_limits(15, 200, 10);
        idle_on = 1'b0;
        send_pixel(8'd77, 16'h5A5A, 1'b1);
        send_pixel(8'd255, 16'h5A5A, 1'b0);
        send_pixel(8'd0, 16'h5A5A, 1'b0);
        send_pixel(8'd0, 16'hFFFF, 1'b0);
        idle_on = 1'b1;
    endtask

    // Full range limits: a zero variance makes every pixel count as motion.
    task automatic test_full_range_limits();
        set_limits(15, 0, 255);
        idle_on = 1'b0;
        send_pixel(8'd10, 16'hA5A5, 1'b1);
        send_pixel(8'd10, 16'hA5A5, 1'b0);
        send_pixel(8'd255, 16'hA5A5, 1'b0);
        send_pixel(8'd255, 16'hA5A5, 1'b0);
        idle_on = 1'b1;
    endtask

    // Random frames over a mostly small set of addresses.
    task automatic run_pixel_phase(input int count);
        int sel;
        int hot;
        logic [sdmd_pkg::ADDR_W-1:0] addr;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (seeded_addrs.size() == 0 || sel < 12)
            begin
                if ($urandom_range(0, 1))
                    addr = sdmd_pkg::ADDR_W'($urandom_range(0, 65535));
                else
                    addr = sdmd_pkg::ADDR_W'($urandom_range(0, 31));
                send_pixel(sdmd_pkg::PIX_W'($urandom_range(0, 255)), addr, 1'b1);
            end
            else
            begin
                hot = (seeded_addrs.size() < HOT_ADDRS) ? seeded_addrs.size() : HOT_ADDRS;
                if (sel < 45 && seeded[last_addr])
                    addr = last_addr;
                else if (sel < 80)
                    addr = seeded_addrs[$urandom_range(0, hot - 1)];
                else
                    addr = seeded_addrs[$urandom_range(0, seeded_addrs.size() - 1)];
                send_pixel(pick_pixel(bg_mean[addr]), addr, 1'b0);
            end
        end
    endtask

    task automatic test_random_frames();
        set_limits(4, 1, 254);
        run_pixel_phase(PHASE_PIXELS);
        set_limits(15, 0, 255);
        run_pixel_phase(PHASE_PIXELS);
        set_limits(1, 10, 40);
        idle_on = 1'b0;
        run_pixel_phase(PHASE_PIXELS);
        idle_on = 1'b1;
        set_limits(8, 255, 0);
        run_pixel_phase(PHASE_PIXELS);
        set_limits(2, 0, 255);
        run_pixel_phase(PHASE_PIXELS);
        set_limits($urandom_range(0, 15), $urandom_range(0, 40), $urandom_range(100, 255));
        run_pixel_phase(PHASE_PIXELS);
    endtask

    // Test sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_zero_gain();
        test_inverted_limits();
        test_full_range_limits();
        test_random_frames();

        wait_idle();
        if (motion_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", motion_q.size()));

        if (error_count == 0)
            $display("tb_sigma_delta_motion_detect_core: clean");
        else
            $display("tb_sigma_delta_motion_detect_core: errors");
        $finish;
    end

endmodule
